// ===== rtl/core/grkc_pkg.sv =====
// shared types, constants and key map for the gamepad report to key code block
package grkc_pkg;

    localparam int AXIS_W   = 8;
    localparam int BTN_W    = 8;
    localparam int CODE_W   = 32;
    localparam int KEY_W    = 21;
    localparam int NUM_AXES = 4;
    localparam int CFG_IDX_W = 2;

    // axis lane positions
    localparam int AX_LX = 0;
    localparam int AX_LY = 1;
    localparam int AX_RX = 2;
    localparam int AX_RY = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_ENTER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_EXIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_EXIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_ENTER = 2'd3;

    localparam logic [AXIS_W-1:0] RST_LOW_ENTER  = 8'd64;
    localparam logic [AXIS_W-1:0] RST_LOW_EXIT   = 8'd112;
    localparam logic [AXIS_W-1:0] RST_HIGH_EXIT  = 8'd144;
    localparam logic [AXIS_W-1:0] RST_HIGH_ENTER = 8'd192;

    localparam logic [7:0] DIR_FLAKY = 8'h99;

    localparam logic [KEY_W-1:0] KEY_NONE      = 21'h000000;
    localparam logic [KEY_W-1:0] KEY_NAV_UP    = 21'h010074;
    localparam logic [KEY_W-1:0] KEY_NAV_DOWN  = 21'h010075;
    localparam logic [KEY_W-1:0] KEY_NAV_RIGHT = 21'h010033;
    localparam logic [KEY_W-1:0] KEY_NAV_LEFT  = 21'h010034;
    localparam logic [KEY_W-1:0] KEY_B0_SEL    = 21'h1ae267;
    localparam logic [KEY_W-1:0] KEY_B0_PAUSE  = 21'h1ae266;
    localparam logic [KEY_W-1:0] KEY_OK        = 21'h010065;
    localparam logic [KEY_W-1:0] KEY_BACK      = 21'h1a490e;
    localparam logic [KEY_W-1:0] KEY_OPTIONS   = 21'h010060;
    localparam logic [KEY_W-1:0] KEY_INFO      = 21'h1ae241;
    localparam logic [KEY_W-1:0] KEY_VOL_UP    = 21'h010012;
    localparam logic [KEY_W-1:0] KEY_VOL_DN    = 21'h010013;
    localparam logic [KEY_W-1:0] KEY_HOME      = 21'h1ae219;
    localparam logic [KEY_W-1:0] KEY_STANDBY   = 21'h1ae215;
    localparam logic [KEY_W-1:0] KEY_PLAY      = 21'h170515;

    typedef enum logic [1:0] {
        LVL_CENTER = 2'd0,
        LVL_LOW    = 2'd1,
        LVL_HIGH   = 2'd2
    } level_t;

    typedef struct packed {
        logic [AXIS_W-1:0] low_enter;
        logic [AXIS_W-1:0] low_exit;
        logic [AXIS_W-1:0] high_exit;
        logic [AXIS_W-1:0] high_enter;
    } thresh_t;

    // fixed priority map from code bytes to key code
    function automatic logic [KEY_W-1:0] map_key(
        input logic [BTN_W-1:0] b0,
        input logic [BTN_W-1:0] b1,
        input logic [BTN_W-1:0] b2,
        input logic [7:0]       d
    );
        logic [KEY_W-1:0] k;
        priority if (d[0])  k = KEY_NAV_UP;
        else if (d[2])      k = KEY_NAV_DOWN;
        else if (d[1])      k = KEY_NAV_RIGHT;
        else if (d[3])      k = KEY_NAV_LEFT;
        else if (b0[4])     k = KEY_NAV_UP;
        else if (b0[5])     k = KEY_NAV_DOWN;
        else if (b0[6])     k = KEY_NAV_RIGHT;
        else if (b0[7])     k = KEY_NAV_LEFT;
        else if (b0[1])     k = KEY_B0_SEL;
        else if (b0[2])     k = KEY_B0_PAUSE;
        else if (b1[6])     k = KEY_OK;
        else if (b1[5])     k = KEY_BACK;
        else if (b1[4])     k = KEY_OPTIONS;
        else if (b1[7])     k = KEY_INFO;
        else if (b1[3])     k = KEY_VOL_UP;
        else if (b1[2])     k = KEY_VOL_DN;
        else if (b0[3])     k = KEY_HOME;
        else if (b2[0])     k = KEY_STANDBY;
        else if (b0[0])     k = KEY_PLAY;
        else                k = KEY_NONE;
        return k;
    endfunction

endpackage

// ===== rtl/core/grkc_axis_lane.sv =====
// one axis lane: three-level hysteresis with its level register
module grkc_axis_lane
    import grkc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  thresh_t           thresh,
    input  logic              advance,
    input  logic [AXIS_W-1:0] sample,
    output level_t            level_next
);

    level_t level_reg;

    always_comb begin
        level_next = level_reg;
        unique case (level_reg)
            LVL_HIGH: begin
                if (sample < thresh.high_exit) level_next = LVL_CENTER;
            end
            LVL_LOW: begin
                if (sample > thresh.low_exit) level_next = LVL_CENTER;
            end
            default: begin
                // high wins when crossed thresholds meet both entries
                if (sample >= thresh.high_enter)     level_next = LVL_HIGH;
                else if (sample <= thresh.low_enter) level_next = LVL_LOW;
                else                                 level_next = LVL_CENTER;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= LVL_CENTER;
        end else if (advance) begin
            level_reg <= level_next;
        end
    end

endmodule

// ===== rtl/core/grkc_merge.sv =====
// merge stage: packs lane levels and buttons, filters changes, maps to key code
module grkc_merge
    import grkc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic                   out_taken,
    input  logic [BTN_W-1:0]       buttons_first,
    input  logic [BTN_W-1:0]       buttons_second,
    input  logic [BTN_W-1:0]       buttons_third,
    input  level_t [NUM_AXES-1:0]  levels,
    output logic                   out_valid,
    output logic [KEY_W-1:0]       out_key
);

    logic [7:0]        dir;
    logic [CODE_W-1:0] code;
    logic [KEY_W-1:0]  key;
    logic              changed;
    logic              emit;

    logic [CODE_W-1:0] prev_code_reg;
    logic              valid_reg;
    logic              valid_next;
    logic [KEY_W-1:0]  key_reg;

    always_comb begin
        dir[0] = (levels[AX_LY] == LVL_LOW);
        dir[1] = (levels[AX_LX] == LVL_HIGH);
        dir[2] = (levels[AX_LY] == LVL_HIGH);
        dir[3] = (levels[AX_LX] == LVL_LOW);
        dir[4] = (levels[AX_RY] == LVL_LOW);
        dir[5] = (levels[AX_RX] == LVL_HIGH);
        dir[6] = (levels[AX_RY] == LVL_HIGH);
        dir[7] = (levels[AX_RX] == LVL_LOW);
    end

    assign code    = {dir, buttons_third, buttons_second, buttons_first};
    assign changed = (code != prev_code_reg);
    assign key     = map_key(buttons_first, buttons_second, buttons_third, dir);
    // flaky direction byte still updates the stored code
    assign emit    = changed && (dir != DIR_FLAKY) && (key != KEY_NONE);

    always_comb begin
        valid_next = valid_reg;
        if (out_taken)       valid_next = 1'b0;
        if (accept && emit)  valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_code_reg <= '0;
            valid_reg     <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (accept && changed) prev_code_reg <= code;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) key_reg <= key;
    end

    assign out_valid = valid_reg;
    assign out_key   = key_reg;

endmodule

// ===== rtl/core/gamepad_report_to_key_code_core.sv =====
// top level: config registers, four axis lanes and the merge stage
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    three button bytes, four axes
//  m_       out        m_valid / m_ready    m_key_code (21 bits)
//  cfg_     in         cfg_wr_en            cfg_index, cfg_wdata
//
// one item per cycle while s_ready is high; a result shows in the cycle after its item is accepted,
// from the single output register after the lanes and the merge logic.
// an item with an unchanged, flaky or unmapped code gives no result.
// s_ready drops only while a result waits and m_ready is low.
// synchronous active-low reset: levels center, stored code zero, thresholds default.
module gamepad_report_to_key_code_core
    import grkc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BTN_W-1:0]     s_buttons_first,
    input  logic [BTN_W-1:0]     s_buttons_second,
    input  logic [BTN_W-1:0]     s_buttons_third,
    input  logic [AXIS_W-1:0]    s_left_x,
    input  logic [AXIS_W-1:0]    s_left_y,
    input  logic [AXIS_W-1:0]    s_right_x,
    input  logic [AXIS_W-1:0]    s_right_y,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [KEY_W-1:0]     m_key_code,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [AXIS_W-1:0]    cfg_wdata
);

    thresh_t               thresh_reg;
    logic                  accept;
    logic [AXIS_W-1:0]     samples [NUM_AXES];
    level_t [NUM_AXES-1:0] levels;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg.low_enter  <= RST_LOW_ENTER;
            thresh_reg.low_exit   <= RST_LOW_EXIT;
            thresh_reg.high_exit  <= RST_HIGH_EXIT;
            thresh_reg.high_enter <= RST_HIGH_ENTER;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LOW_ENTER:  thresh_reg.low_enter  <= cfg_wdata;
                REG_LOW_EXIT:   thresh_reg.low_exit   <= cfg_wdata;
                REG_HIGH_EXIT:  thresh_reg.high_exit  <= cfg_wdata;
                REG_HIGH_ENTER: thresh_reg.high_enter <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_ready = !m_valid || m_ready;
    assign accept  = s_valid && s_ready;

    assign samples[AX_LX] = s_left_x;
    assign samples[AX_LY] = s_left_y;
    assign samples[AX_RX] = s_right_x;
    assign samples[AX_RY] = s_right_y;

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
        grkc_axis_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .thresh     (thresh_reg),
            .advance    (accept),
            .sample     (samples[i]),
            .level_next (levels[i])
        );
    end

    grkc_merge u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .out_taken      (m_valid && m_ready),
        .buttons_first  (s_buttons_first),
        .buttons_second (s_buttons_second),
        .buttons_third  (s_buttons_third),
        .levels         (levels),
        .out_valid      (m_valid),
        .out_key        (m_key_code)
    );

endmodule

// ===== rtl/core/grkc_checker.sv =====
// port-level checker for the gamepad report to key code block, with its bind
module grkc_checker
    import grkc_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [KEY_W-1:0] m_key_code
);

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_key_code))
        else $error("result dropped or changed while stalled");

    // a mapped key code is never zero
    a_key_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_key_code != KEY_NONE)
        else $error("zero key code delivered");

    // input side only stalls behind a waiting result
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input stalled with free output register");

    // no result appears without an accepted item
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !(s_valid && s_ready) |=> !m_valid)
        else $error("result without an accepted item");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind gamepad_report_to_key_code_core grkc_checker u_grkc_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_key_code (m_key_code)
);
